[hw/rtl/rchb_pkg.sv]
// rchb_pkg: shared types, codes and the hopping table of the hop-bind receiver.
// No dependencies; imported by every module of the block.
package rchb_pkg;

   localparam int unsigned PACKET_BYTES = 16;
   localparam int unsigned ID_FIRST_POS = 7;
   localparam int unsigned FLAG_POS     = 14;

   localparam logic [3:0]  LAST_POS      = 4'(PACKET_BYTES - 1);
   localparam logic [3:0]  ID_FIRST      = 4'(ID_FIRST_POS);
   localparam logic [3:0]  ID_LAST       = 4'(ID_FIRST_POS + 2);
   localparam logic [3:0]  FLAG_AT       = 4'(FLAG_POS);
   localparam logic [7:0]  BIND_FLAG     = 8'hC0;
   localparam logic [15:0] TIMEOUT_RESET = 16'd200;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic EVENT_PACKET   = 1'b0;
   localparam logic EVENT_FAILSAFE = 1'b1;

   localparam logic [0:3][0:15][7:0] HOP_ROWS = {
      {8'h27, 8'h1B, 8'h39, 8'h28, 8'h24, 8'h22, 8'h2E, 8'h36,
       8'h19, 8'h21, 8'h29, 8'h14, 8'h1E, 8'h12, 8'h2D, 8'h18},
      {8'h2E, 8'h33, 8'h25, 8'h38, 8'h19, 8'h12, 8'h18, 8'h16,
       8'h2A, 8'h1C, 8'h1F, 8'h37, 8'h2F, 8'h23, 8'h34, 8'h10},
      {8'h11, 8'h1A, 8'h35, 8'h24, 8'h28, 8'h18, 8'h25, 8'h2A,
       8'h32, 8'h2C, 8'h14, 8'h27, 8'h36, 8'h34, 8'h1C, 8'h17},
      {8'h22, 8'h27, 8'h17, 8'h39, 8'h34, 8'h28, 8'h2B, 8'h1D,
       8'h18, 8'h2A, 8'h21, 8'h38, 8'h10, 8'h26, 8'h20, 8'h1F}
   };

   typedef struct packed {
      logic       op;
      logic [7:0] byte_value;
      logic       first_byte;
   } item_type;

   typedef struct packed {
      logic       emit;
      logic       event_kind;
      logic [6:0] next_channel;
      logic       packet_valid;
      logic       is_bound;
   } result_type;

endpackage

[hw/rtl/rchb_chan.sv]
// rchb_chan: channel for a hop index, from the bind row or the bound work row.
// Depends on rchb_pkg (hopping table).
module rchb_chan
   import rchb_pkg::*;
(
   input  logic [4:0] hop_index,
   input  logic       bound,
   input  logic [1:0] row,
   input  logic [2:0] increment,
   output logic [6:0] channel
);

   logic [3:0] slot;
   logic [7:0] work;
   logic [7:0] adj;

   assign slot = hop_index[4:1];
   assign work = HOP_ROWS[row][slot] + {5'd0, increment};
   // zero low nibble is nudged down by three
   assign adj  = (work[3:0] == 4'd0) ? work - 8'd3 : work;

   always_comb begin
      if (bound) begin
         channel = adj[6:0];
      end else begin
         channel = HOP_ROWS[0][slot][6:0];
      end
   end

endmodule

[hw/rtl/rchb_step.sv]
// rchb_step: receiver state and the per-word update (bytes and ticks).
// Depends on rchb_pkg and rchb_chan.
module rchb_step
   import rchb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  item_type    item,
   input  logic [15:0] timeout,
   output result_type  result
);

   logic [3:0]  pos_ff,   pos_in;
   logic [7:0]  sum_ff,   sum_in;
   logic [7:0]  id_ff,    id_in;
   logic [7:0]  flag_ff,  flag_in;
   logic [4:0]  idx_ff,   idx_in;
   logic        bound_ff, bound_in;
   logic [1:0]  row_ff,   row_in;
   logic [2:0]  inc_ff,   inc_in;
   logic [15:0] idle_ff,  idle_in;

   logic [3:0]  pos;
   logic [7:0]  sum_base;
   logic [7:0]  id_base;
   logic [15:0] idle_up;
   logic        chk_ok;
   logic [6:0]  channel;

   assign pos      = item.first_byte ? 4'd0 : pos_ff;
   assign sum_base = (pos == 4'd0) ? 8'd0 : sum_ff;
   assign id_base  = (pos == 4'd0) ? 8'd0 : id_ff;
   assign idle_up  = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
   assign chk_ok   = (item.byte_value == sum_ff);

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      id_in    = id_ff;
      flag_in  = flag_ff;
      idx_in   = idx_ff;
      bound_in = bound_ff;
      row_in   = row_ff;
      inc_in   = inc_ff;
      idle_in  = idle_ff;
      result.emit         = 1'b0;
      result.event_kind   = EVENT_PACKET;
      result.packet_valid = 1'b0;
      if (item.op == OP_TICK) begin
         idle_in = idle_up;
         if (idle_up > timeout) begin
            idx_in            = idx_ff + 5'd1;
            idle_in           = 16'd0;
            result.emit       = 1'b1;
            result.event_kind = EVENT_FAILSAFE;
         end
      end else if (pos != LAST_POS) begin
         pos_in = pos + 4'd1;
         sum_in = sum_base + item.byte_value;
         id_in  = id_base;
         if (pos >= ID_FIRST && pos <= ID_LAST) begin
            id_in = id_base + item.byte_value;
         end
         if (pos == FLAG_AT) begin
            flag_in = item.byte_value;
         end
      end else begin
         // checksum byte closes the packet
         pos_in = 4'd0;
         if (chk_ok && !bound_ff && flag_ff == BIND_FLAG) begin
            row_in   = id_ff[1:0];
            inc_in   = id_ff[4:2];
            bound_in = 1'b1;
         end
         idx_in              = idx_ff + 5'd1;
         idle_in             = 16'd0;
         result.emit         = 1'b1;
         result.packet_valid = chk_ok;
      end
      result.is_bound     = bound_in;
      result.next_channel = channel;
   end

   rchb_chan u_chan (
      .hop_index (idx_in),
      .bound     (bound_in),
      .row       (row_in),
      .increment (inc_in),
      .channel   (channel)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         id_ff    <= '0;
         flag_ff  <= '0;
         idx_ff   <= '0;
         bound_ff <= 1'b0;
         row_ff   <= '0;
         inc_ff   <= '0;
         idle_ff  <= '0;
      end else if (fire) begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         id_ff    <= id_in;
         flag_ff  <= flag_in;
         idx_ff   <= idx_in;
         bound_ff <= bound_in;
         row_ff   <= row_in;
         inc_ff   <= inc_in;
         idle_ff  <= idle_in;
      end
   end

endmodule

[hw/rtl/rc_receiver_hop_bind.sv]
// rc_receiver_hop_bind: top level of the hop-bind receiver.
// Depends on rchb_pkg and rchb_step (which uses rchb_chan).
//
// Receive side of a frequency-hopping remote-control link. Each input word is
// either one packet byte (op 0) or a one-millisecond tick (op 1). A 16-byte
// packet ends with a checksum byte; that byte yields one result word with the
// next channel, the checksum verdict and the bound status. A valid packet with
// flag byte 0xC0 binds an unbound receiver to the transmitter's hop pattern.
// More than csr timeout ticks without a packet yields a failsafe result word.
// Timing: a word is registered on entry, the state update and channel lookup
// run on it, and the result lands in an output register; one word is accepted
// every cycle unless req_stall is high. The output register frees the input
// side: words that make no result keep flowing while a result waits; only a
// result-making word waits on a held output register. Users must write the
// timeout register with csr_wr_en only while the block is idle; not enforced.
module rc_receiver_hop_bind
   import rchb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_byte_value,
   input  logic        req_first_byte,
   // result words
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_event_kind,
   output logic [6:0]  rsp_next_channel,
   output logic        rsp_packet_valid,
   output logic        rsp_is_bound,
   // timeout register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic        in_valid_ff, in_valid_in;
   item_type    item_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;
   logic [15:0] timeout_ff;

   result_type  result;
   logic        out_free;
   logic        fire;
   logic        take;

   // output register can take a new result this cycle
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   // words without a result never wait on the output side
   assign fire        = in_valid_ff && (out_free || !result.emit);
   assign req_stall   = in_valid_ff && !fire;
   assign take        = req_valid && !req_stall;
   assign in_valid_in = take || (in_valid_ff && !fire);

   always_comb begin
      if (fire && result.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   rchb_step u_step (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (item_ff),
      .timeout (timeout_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.op         <= req_op;
         item_ff.byte_value <= req_byte_value;
         item_ff.first_byte <= req_first_byte;
      end
      if (fire && result.emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_ff.event_kind;
   assign rsp_next_channel = rsp_ff.next_channel;
   assign rsp_packet_valid = rsp_ff.packet_valid;
   assign rsp_is_bound     = rsp_ff.is_bound;

endmodule
